// File: hdl/csp_pkg.sv
// Package for the circle segment push-out block: shared types, codes and constants.
// Used by csp_iter_unit and circle_segment_pushout; depends on nothing else.
package csp_pkg;

  // Default size of the wall table
  localparam int MAX_WALLS_DEF = 8;

  // Iterative unit word width and step counter width
  localparam int WORD_W = 64;
  localparam int STEP_W = 6;

  // Step counts of the iterative unit
  localparam logic [STEP_W-1:0] MUL_STEPS  = 6'd32;
  localparam logic [STEP_W-1:0] DIVT_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd24;
  localparam logic [STEP_W-1:0] PUSH_STEPS = 6'd42;

  // First trial bit of the square root and the rounding half of 2^32
  localparam logic [WORD_W-1:0] SQRT_BIT0 = 64'h0000_4000_0000_0000;
  localparam logic [WORD_W-1:0] HALF32    = 64'h0000_0000_8000_0000;

  // Input commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COLLIDE = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } csp_op_t;

  typedef struct packed {
    logic              go;
    csp_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [STEP_W-1:0] steps;
  } csp_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } csp_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RR, S_CHECK, S_SETUP, S_P1, S_P2, S_VIS, S_D1, S_D2, S_M1, S_M2,
    S_PROJ, S_DIVT, S_CX, S_CY, S_V, S_VX, S_VY, S_HIT, S_SQRT, S_OXM, S_OXD,
    S_OYM, S_OYD
  } csp_state_t;

endpackage

// File: hdl/csp_iter_unit.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, bitwise square root.
// One step per cycle. Depends on csp_pkg.
module csp_iter_unit import csp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  csp_req_t req,
  output csp_rsp_t rsp
);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  csp_op_t           op_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] lo_r;
  logic [WORD_W-1:0] q_r;
  logic [WORD_W-1:0] div_r;

  logic [WORD_W-1:0] rem2;
  logic              dge;
  logic [WORD_W-1:0] sq_sum;
  logic              sge;
  logic [WORD_W-1:0] madd;

  // one step of each operation
  always_comb begin
    rem2   = {rem_r[WORD_W-2:0], lo_r[WORD_W-1]};
    dge    = rem2 >= div_r;
    sq_sum = q_r + lo_r;
    sge    = rem_r >= sq_sum;
    madd   = rem_r + lo_r;
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= req.steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load operands, then advance one step a cycle
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_r  <= req.op;
      rem_r <= req.a;
      lo_r  <= req.c;
      q_r   <= (req.op == OP_MUL) ? req.b : '0;
      div_r <= req.b;
    end else if (run_r) begin
      case (op_r)
        OP_MUL: begin
          if (q_r[0]) rem_r <= madd;
          lo_r <= lo_r << 1;
          q_r  <= q_r >> 1;
        end
        OP_DIV: begin
          rem_r <= dge ? (rem2 - div_r) : rem2;
          q_r   <= {q_r[WORD_W-2:0], dge};
          lo_r  <= lo_r << 1;
        end
        OP_SQRT: begin
          if (sge) begin
            rem_r <= rem_r - sq_sum;
            q_r   <= (q_r >> 1) + lo_r;
          end else begin
            q_r <= q_r >> 1;
          end
          lo_r <= lo_r >> 2;
        end
        default: begin
          lo_r <= lo_r;
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = (op_r == OP_MUL) ? rem_r : q_r;

endmodule

// File: hdl/circle_segment_pushout.sv
// Top level of the circle segment push-out block: wall table, sequencer and result port.
// Depends on csp_pkg and csp_iter_unit.
//
// A load word (in_command 0) writes one wall into the table in the cycle it is taken and
// leaves busy low. A collide word raises busy until its result has been shown. All of the
// arithmetic goes into the one shared multiply/divide/square-root unit, which retires one
// bit per cycle: 32 steps per multiply and projection divide, 24 for the square root, 42
// for each push divide. The result word appears on the out_ ports for exactly one cycle
// with out_valid; the receiver cannot stall it, so it must take every word as it comes.
// Write cfg_data only while idle.
module circle_segment_pushout import csp_pkg::*; #(
  parameter int MAX_WALLS = MAX_WALLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [2:0]         in_wall_slot,
  input  logic signed [23:0] in_from_x,
  input  logic signed [23:0] in_from_y,
  input  logic signed [23:0] in_to_x,
  input  logic signed [23:0] in_to_y,
  input  logic signed [23:0] in_body_x,
  input  logic signed [23:0] in_body_y,
  input  logic [15:0]        in_body_radius,
  output logic               out_valid,
  output logic signed [23:0] out_new_x,
  output logic signed [23:0] out_new_y,
  output logic               out_hit_ground,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  localparam int WIDX = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int NW   = $clog2(MAX_WALLS + 1);

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607)       sat24 = 24'sh7FFFFF;
    else if (v < -64'sd8388608) sat24 = 24'sh800000;
    else                        sat24 = v[23:0];
  endfunction

  csp_state_t state_r, state_nxt;
  csp_req_t   req;
  csp_rsp_t   rsp;
  logic       pend_r;

  logic [3:0]          active_r;
  logic [NW-1:0]       wc_r, n_r;
  logic [95:0]         mem [MAX_WALLS];
  logic [95:0]         rd_r;
  logic signed [23:0]  px_r, py_r, cx_r, cy_r;
  logic [15:0]         r_r;
  logic [31:0]         rr_r;
  logic                ground_r;
  logic signed [24:0]  dx_r, dy_r, apx_r, apy_r, vx_r, vy_r;
  logic signed [25:0]  rx_r, ry_r;
  logic signed [63:0]  pa_r, pb_r;
  logic [63:0]         tmp_r;
  logic [23:0]         cd_r;
  logic                out_valid_r, out_ground_r;
  logic signed [23:0]  out_x_r, out_y_r;

  logic signed [23:0]  sx, sy, ex, ey;
  logic                accept, wr_en, psgn, rsgn, osgn;
  logic [63:0]         mdx, mdy, mrx, mry, mapx, mapy, mvx, mvy, rnd_q;
  logic signed [63:0]  prod_s, rnd_s, cpt, off_s, psum;
  logic [NW-1:0]       n_calc;

  assign {sx, sy, ex, ey} = rd_r;
  assign accept    = start && (state_r == S_IDLE);
  assign wr_en     = accept && (in_command == CMD_LOAD) && (int'(in_wall_slot) < MAX_WALLS);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign n_calc    = (int'(active_r) > MAX_WALLS) ? NW'(MAX_WALLS) : NW'(active_r);

  csp_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // magnitudes and signed results of the unit
  always_comb begin
    mdx   = abs64(64'(dx_r));
    mdy   = abs64(64'(dy_r));
    mrx   = abs64(64'(rx_r));
    mry   = abs64(64'(ry_r));
    mapx  = abs64(64'(apx_r));
    mapy  = abs64(64'(apy_r));
    mvx   = abs64(64'(vx_r));
    mvy   = abs64(64'(vy_r));
    case (state_r)
      S_P1:    psgn = dx_r[24] ^ ry_r[25];
      S_P2:    psgn = dy_r[24] ^ rx_r[25];
      S_D1:    psgn = apx_r[24] ^ dx_r[24];
      S_D2:    psgn = apy_r[24] ^ dy_r[24];
      default: psgn = 1'b0;
    endcase
    prod_s = psgn ? -$signed(rsp.value) : $signed(rsp.value);
    rsgn   = (state_r == S_CX) ? dx_r[24] : dy_r[24];
    rnd_q  = (rsp.value + HALF32) >> 32;
    rnd_s  = rsgn ? -$signed(rnd_q) : $signed(rnd_q);
    cpt    = ((state_r == S_CX) ? 64'(sx) : 64'(sy)) + rnd_s;
    osgn   = (state_r == S_OXD) ? vx_r[24] : vy_r[24];
    off_s  = osgn ? -$signed(rsp.value) : $signed(rsp.value);
    psum   = ((state_r == S_OXD) ? 64'(cx_r) : 64'(cy_r)) - off_s;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start && in_command == CMD_COLLIDE) state_nxt = S_RR;
      S_RR:    if (rsp.done) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (wc_r == n_r) ? S_IDLE : S_SETUP;
      S_SETUP: state_nxt = S_P1;
      S_P1:    if (rsp.done) state_nxt = S_P2;
      S_P2:    if (rsp.done) state_nxt = S_VIS;
      S_VIS:   state_nxt = (pa_r > pb_r) ? S_D1 : S_CHECK;
      S_D1:    if (rsp.done) state_nxt = S_D2;
      S_D2:    if (rsp.done) state_nxt = S_M1;
      S_M1:    if (rsp.done) state_nxt = S_M2;
      S_M2:    if (rsp.done) state_nxt = S_PROJ;
      S_PROJ:  state_nxt = (pa_r <= 0 || pa_r >= pb_r) ? S_V : S_DIVT;
      S_DIVT:  if (rsp.done) state_nxt = S_CX;
      S_CX:    if (rsp.done) state_nxt = S_CY;
      S_CY:    if (rsp.done) state_nxt = S_V;
      S_V:     state_nxt = S_VX;
      S_VX:    if (rsp.done) state_nxt = S_VY;
      S_VY:    if (rsp.done) state_nxt = S_HIT;
      S_HIT: begin
        if (pa_r > $signed(64'(rr_r)) || pa_r == 0) state_nxt = S_CHECK;
        else                                          state_nxt = S_SQRT;
      end
      S_SQRT:  if (rsp.done) state_nxt = S_OXM;
      S_OXM:   if (rsp.done) state_nxt = S_OXD;
      S_OXD:   if (rsp.done) state_nxt = S_OYM;
      S_OYM:   if (rsp.done) state_nxt = S_OYD;
      S_OYD:   if (rsp.done) state_nxt = S_CHECK;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit requests per state
  always_comb begin
    req       = '0;
    req.op    = OP_MUL;
    req.steps = MUL_STEPS;
    case (state_r)
      S_RR:   begin req.go = !pend_r; req.c = 64'(r_r); req.b = 64'(r_r); end
      S_P1:   begin req.go = !pend_r; req.c = mdx;  req.b = mry; end
      S_P2:   begin req.go = !pend_r; req.c = mdy;  req.b = mrx; end
      S_D1:   begin req.go = !pend_r; req.c = mapx; req.b = mdx; end
      S_D2:   begin req.go = !pend_r; req.c = mapy; req.b = mdy; end
      S_M1:   begin req.go = !pend_r; req.c = mdx;  req.b = mdx; end
      S_M2:   begin req.go = !pend_r; req.c = mdy;  req.b = mdy; end
      S_CX:   begin req.go = !pend_r; req.c = mdx;  req.b = tmp_r; end
      S_CY:   begin req.go = !pend_r; req.c = mdy;  req.b = tmp_r; end
      S_VX:   begin req.go = !pend_r; req.c = mvx;  req.b = mvx; end
      S_VY:   begin req.go = !pend_r; req.c = mvy;  req.b = mvy; end
      S_OXM:  begin req.go = !pend_r; req.c = mvx << 8; req.b = 64'(r_r); end
      S_OYM:  begin req.go = !pend_r; req.c = mvy << 8; req.b = 64'(r_r); end
      S_DIVT: begin
        req.go = !pend_r; req.op = OP_DIV; req.steps = DIVT_STEPS;
        req.a  = 64'(pa_r); req.b = 64'(pb_r);
      end
      S_SQRT: begin
        req.go = !pend_r; req.op = OP_SQRT; req.steps = SQRT_STEPS;
        req.a  = 64'(pa_r) << 16; req.c = SQRT_BIT0;
      end
      S_OXD, S_OYD: begin
        req.go = !pend_r; req.op = OP_DIV; req.steps = PUSH_STEPS;
        req.b  = 64'(cd_r);
        req.c  = (tmp_r + 64'(cd_r >> 1)) << 22;
      end
      default: req.go = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      active_r    <= '0;
      wc_r        <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_CHECK) && (wc_r == n_r);
      if (req.go)        pend_r <= 1'b1;
      else if (rsp.done) pend_r <= 1'b0;
      if (cfg_valid && cfg_ready) active_r <= cfg_data;
      if (accept) begin
        wc_r <= '0;
        n_r  <= n_calc;
      end else if (state_nxt == S_CHECK && state_r != S_RR && state_r != S_IDLE) begin
        wc_r <= wc_r + 1'b1;
      end
    end
  end

  // wall table: write on load, registered read of the current wall
  always_ff @(posedge clk) begin
    if (wr_en) mem[WIDX'(in_wall_slot)] <= {in_from_x, in_from_y, in_to_x, in_to_y};
    rd_r <= mem[wc_r[WIDX-1:0]];
  end

  // datapath registers: capture setup values and unit results
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r     <= in_body_x;
      py_r     <= in_body_y;
      r_r      <= in_body_radius;
      ground_r <= 1'b0;
    end
    case (state_r)
      S_RR: if (rsp.done) rr_r <= rsp.value[31:0];
      S_SETUP: begin
        dx_r  <= 25'(ex) - 25'(sx);
        dy_r  <= 25'(ey) - 25'(sy);
        rx_r  <= (26'(px_r) <<< 1) - 26'(sx) - 26'(ex);
        ry_r  <= (26'(py_r) <<< 1) - 26'(sy) - 26'(ey);
        apx_r <= 25'(px_r) - 25'(sx);
        apy_r <= 25'(py_r) - 25'(sy);
      end
      S_P1, S_D1: if (rsp.done) pa_r <= prod_s;
      S_P2:       if (rsp.done) pb_r <= prod_s;
      S_D2, S_VY: if (rsp.done) pa_r <= pa_r + prod_s;
      S_VX:       if (rsp.done) pa_r <= prod_s;
      S_M1:       if (rsp.done) pb_r <= prod_s;
      S_M2:       if (rsp.done) pb_r <= pb_r + prod_s;
      S_PROJ: begin
        if (pa_r <= 0) begin
          cx_r <= sx;
          cy_r <= sy;
        end else if (pa_r >= pb_r) begin
          cx_r <= ex;
          cy_r <= ey;
        end
      end
      S_DIVT: if (rsp.done) tmp_r <= rsp.value;
      S_CX:   if (rsp.done) cx_r <= cpt[23:0];
      S_CY:   if (rsp.done) cy_r <= cpt[23:0];
      S_V: begin
        vx_r <= 25'(cx_r) - 25'(px_r);
        vy_r <= 25'(cy_r) - 25'(py_r);
      end
      S_HIT: begin
        // a touch with the centre on the wall still counts for ground
        if (pa_r == 0 && dx_r[24]) ground_r <= 1'b1;
      end
      S_SQRT: if (rsp.done) cd_r <= rsp.value[23:0];
      S_OXM, S_OYM: if (rsp.done) tmp_r <= rsp.value;
      S_OXD: if (rsp.done) px_r <= sat24(psum);
      S_OYD: begin
        if (rsp.done) begin
          py_r <= sat24(psum);
          if (dx_r[24]) ground_r <= 1'b1;
        end
      end
      default: tmp_r <= tmp_r;
    endcase
  end

  // result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK && wc_r == n_r) begin
      out_x_r      <= px_r;
      out_y_r      <= py_r;
      out_ground_r <= ground_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_x      = out_x_r;
  assign out_new_y      = out_y_r;
  assign out_hit_ground = out_ground_r;

endmodule

// File: bench/tb.sv
// Testbench for circle_segment_pushout: directed table, then constrained-by-hand random words.
// Depends on csp_pkg and the circle_segment_pushout RTL; checks results against a local predictor.
`timescale 1ns / 1ps

module tb import csp_pkg::*; ();

  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam int WATCH_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    bit                is_cfg;
    logic [3:0]        cfg_val;
    logic              cmd;
    logic [2:0]        slot;
    logic signed [23:0] fx, fy, tx, ty, bx, by;
    logic [15:0]       rad;
    bit                has_exp;
    logic signed [23:0] ex, ey;
    logic              eg;
  } word_t;

  typedef struct {
    logic signed [23:0] x, y;
    logic              g;
  } centre_t;

  logic clk, rst_n, start, busy;
  logic in_command;
  logic [2:0] in_wall_slot;
  logic signed [23:0] in_from_x, in_from_y, in_to_x, in_to_y, in_body_x, in_body_y;
  logic [15:0] in_body_radius;
  logic out_valid, out_hit_ground;
  logic signed [23:0] out_new_x, out_new_y;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_data;

  // wall table and register copy held by the predictor
  longint wsx[8], wsy[8], wex[8], wey[8];
  int walls_on;
  centre_t centre_q[$];
  int mismatches;
  int idle_pct;
  int quiet_cycles;

  circle_segment_pushout DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_wall_slot(in_wall_slot),
    .in_from_x(in_from_x), .in_from_y(in_from_y), .in_to_x(in_to_x), .in_to_y(in_to_y),
    .in_body_x(in_body_x), .in_body_y(in_body_y), .in_body_radius(in_body_radius),
    .out_valid(out_valid), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_hit_ground(out_hit_ground),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_div(longint n, longint den);
    longint mag, q;
    mag = n < 0 ? -n : n;
    q = (mag + den / 2) / den;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // push the centre out of every active wall in slot order
  function automatic centre_t push_out(word_t w);
    centre_t res;
    longint px, py, r, dx, dy, rx, ry, cx, cy, vx, vy, d, t, rem, m;
    longint unsigned cd2, cd;
    int n;
    bit g;
    px = w.bx;
    py = w.by;
    r = longint'({1'b0, w.rad});
    g = 1'b0;
    n = walls_on > 8 ? 8 : walls_on;
    for (int i = 0; i < n; i++) begin
      dx = wex[i] - wsx[i];
      dy = wey[i] - wsy[i];
      rx = 2 * px - wsx[i] - wex[i];
      ry = 2 * py - wsy[i] - wey[i];
      if (-dy * rx + dx * ry <= 0) continue;
      // closest point, projection clamped to the segment
      d = (px - wsx[i]) * dx + (py - wsy[i]) * dy;
      m = dx * dx + dy * dy;
      if (d <= 0) begin
        cx = wsx[i]; cy = wsy[i];
      end else if (d >= m) begin
        cx = wex[i]; cy = wey[i];
      end else begin
        rem = d;
        t = 0;
        for (int k = 0; k < 32; k++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= m) begin
            rem -= m;
            t |= 1;
          end
        end
        cx = wsx[i] + round_div(dx * t, 64'sd1 << 32);
        cy = wsy[i] + round_div(dy * t, 64'sd1 << 32);
      end
      vx = cx - px;
      vy = cy - py;
      cd2 = longint'(vx * vx) + longint'(vy * vy);
      if (cd2 > longint'(r * r)) continue;
      if (cd2 != 0) begin
        cd = int_sqrt(cd2 << 16);
        px = sat_coord(cx - round_div(vx * r * 256, longint'(cd)));
        py = sat_coord(cy - round_div(vy * r * 256, longint'(cd)));
      end
      if (dx < 0) g = 1'b1;
    end
    res.x = px[23:0];
    res.y = py[23:0];
    res.g = g;
    return res;
  endfunction

  function automatic void report(string what, logic [23:0] e, logic [23:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, $signed(e), $signed(a));
  endfunction

  // take each result word as it is shown
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (centre_q.size() == 0) begin
        report("unexpected result", 24'd0, out_new_x);
      end else begin
        centre_t e;
        e = centre_q.pop_front();
        if (out_new_x !== e.x) report("new_x", e.x, out_new_x);
        if (out_new_y !== e.y) report("new_y", e.y, out_new_y);
        if (out_hit_ground !== e.g) report("hit_ground", {23'd0, e.g}, {23'd0, out_hit_ground});
      end
    end
  end

  // watchdog: count cycles in which no word moves anywhere
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("circle_segment_pushout test failed");
      $finish;
    end
  end

  // hold the sender until every result is back, then drain
  task automatic settle();
    start <= 1'b0;
    while (centre_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_walls_on(logic [3:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    walls_on = int'(v);
  endtask

  task automatic send(word_t w);
    centre_t e;
    in_command <= w.cmd;
    in_wall_slot <= w.slot;
    in_from_x <= w.fx; in_from_y <= w.fy;
    in_to_x <= w.tx; in_to_y <= w.ty;
    in_body_x <= w.bx; in_body_y <= w.by;
    in_body_radius <= w.rad;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // word taken at this edge: advance the predictor
    if (w.cmd == CMD_LOAD) begin
      wsx[w.slot] = w.fx; wsy[w.slot] = w.fy;
      wex[w.slot] = w.tx; wey[w.slot] = w.ty;
    end else begin
      e = push_out(w);
      if (w.has_exp && (e.x !== w.ex || e.y !== w.ey || e.g !== w.eg))
        report("table entry", w.ex, e.x);
      centre_q.push_back(e);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  function automatic word_t load_word(int s, longint fx, longint fy, longint tx, longint ty);
    word_t w;
    w = '{default: '0};
    w.cmd = CMD_LOAD; w.slot = s[2:0];
    w.fx = fx[23:0]; w.fy = fy[23:0]; w.tx = tx[23:0]; w.ty = ty[23:0];
    w.bx = 24'($urandom); w.by = 24'($urandom); w.rad = 16'($urandom);
    return w;
  endfunction

  function automatic word_t collide_word(longint bx, longint by, int r);
    word_t w;
    w = '{default: '0};
    w.cmd = CMD_COLLIDE; w.slot = 3'($urandom);
    w.fx = 24'($urandom); w.fy = 24'($urandom); w.tx = 24'($urandom); w.ty = 24'($urandom);
    w.bx = bx[23:0]; w.by = by[23:0]; w.rad = r[15:0];
    return w;
  endfunction

  function automatic word_t cfg_word(int v);
    word_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.cfg_val = v[3:0];
    return w;
  endfunction

  function automatic word_t rand_word();
    longint c0, c1, hx, hy;
    int s;
    if ($urandom_range(99) < 25) begin
      s = $urandom_range(7);
      case ($urandom_range(9))
        0, 1: return load_word(s, $signed(24'($urandom)), $signed(24'($urandom)),
                               $signed(24'($urandom)), $signed(24'($urandom)));
        2: begin
          c0 = $urandom_range(65535) - 32768;
          return load_word(s, c0, -c0, c0, -c0);
        end
        default: begin
          c0 = longint'($urandom_range(131071)) - 65536;
          c1 = longint'($urandom_range(131071)) - 65536;
          hx = longint'($urandom_range(65535)) - 32768;
          hy = longint'($urandom_range(65535)) - 32768;
          return load_word(s, c0 - hx, c1 - hy, c0 + hx, c1 + hy);
        end
      endcase
    end
    if ($urandom_range(99) < 20)
      return collide_word($signed(24'($urandom)), $signed(24'($urandom)), $urandom);
    // aim near a wall midpoint so that pushes happen
    s = $urandom_range(7);
    c0 = (wsx[s] + wex[s]) / 2 + longint'($urandom_range(131071)) - 65536;
    c1 = (wsy[s] + wey[s]) / 2 + longint'($urandom_range(131071)) - 65536;
    return collide_word(sat_coord(c0), sat_coord(c1), $urandom_range(65535));
  endfunction

  word_t plan[$];

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    in_command = CMD_LOAD; in_wall_slot = '0;
    in_from_x = '0; in_from_y = '0; in_to_x = '0; in_to_y = '0;
    in_body_x = '0; in_body_y = '0; in_body_radius = '0;
    mismatches = 0; walls_on = 0; idle_pct = 0;
    foreach (wsx[i]) begin
      wsx[i] = 0; wsy[i] = 0; wex[i] = 0; wey[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: no walls active after reset, so the centre comes back unchanged
    plan.push_back(collide_word(CMAX, CMIN, 65535));
    plan[$].has_exp = 1; plan[$].ex = CMAX[23:0]; plan[$].ey = CMIN[23:0]; plan[$].eg = 0;
    plan.push_back(collide_word(CMIN, CMAX, 0));
    plan[$].has_exp = 1; plan[$].ex = CMIN[23:0]; plan[$].ey = CMAX[23:0]; plan[$].eg = 0;
    plan.push_back(load_word(0, 4096, 0, -4096, 0));          // ground wall
    plan.push_back(load_word(1, 256, 256, 256, 256));         // zero-length wall
    plan.push_back(load_word(2, 0, -4096, 0, 4096));
    plan.push_back(load_word(3, CMIN, CMIN, CMAX, CMAX));     // full-range diagonal
    plan.push_back(load_word(4, 1000, 5000, 3000, 5000));
    plan.push_back(load_word(5, -20000, -20000, -20000, -30000));
    plan.push_back(load_word(6, CMAX, CMIN, CMIN, CMAX));
    plan.push_back(load_word(7, CMAX - 100, 1000, CMAX - 100, -1000)); // pushes past the edge
    plan.push_back(cfg_word(8));
    plan.push_back(collide_word(0, -512, 1024));
    plan.push_back(collide_word(-256, 200, 65535));
    plan.push_back(collide_word(2000, 5000, 300));            // centre on a wall
    plan.push_back(collide_word(CMAX - 50, 0, 65535));
    plan.push_back(collide_word(256, 256, 65535));
    plan.push_back(collide_word(-20100, -25000, 512));
    plan.push_back(cfg_word(15));
    plan.push_back(collide_word(0, -512, 1024));
    plan.push_back(collide_word(CMAX - 50, 0, 65535));
    plan.push_back(cfg_word(1));
    plan.push_back(collide_word(0, -300, 65535));
    plan.push_back(collide_word(0, 300, 65535));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_walls_on(plan[i].cfg_val);
      else send(plan[i]);
    end

    // random phases, each setting the register value and the idling mix
    for (int ph = 0; ph < 6; ph++) begin
      int v;
      case (ph)
        0: v = 8;
        1: v = 3;
        2: v = 15;
        3: v = 0;
        default: v = $urandom_range(15);
      endcase
      write_walls_on(v[3:0]);
      case (ph % 4)
        1: idle_pct = 86;
        3: idle_pct = 27;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 150; k++) begin
        if (k == 75) settle();
        send(rand_word());
      end
    end

    settle();
    if (mismatches == 0)
      $display("circle_segment_pushout test passed");
    else
      $display("circle_segment_pushout test failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/csp_pkg.sv
hdl/csp_iter_unit.sv
hdl/circle_segment_pushout.sv
bench/tb.sv
